// File: src/ncpq_pkg.sv
// Shared constants, types and fixed-point formats of the NCP quality estimator.
package ncpq_pkg;

    // Fixed-point formats.
    localparam int Q24_FRAC = 24;
    localparam int Q30_FRAC = 30;
    localparam int Q30_W = Q30_FRAC + 1;
    localparam int CNT_FRAC = 2 * Q24_FRAC;

    // Exponential unit: one square root per fraction bit of a Q16 exponent.
    localparam int POW2_BITS = 16;
    localparam int SQ_W = 2 * Q30_W;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int POW2_LAT = POW2_BITS * SQ_STEPS + 1;

    // Gate and count limits.
    localparam int MAX_GATES = 1024;
    localparam int MAX_COUNT = 1023;

    typedef logic [Q30_W-1:0] q30_t;

    localparam q30_t ONE_Q30 = 31'h4000_0000;
    localparam q30_t TENTH_Q30 = 31'd107374182;

    localparam logic [23:0] NCP_LO_Q24 = 24'd16777;
    localparam logic [23:0] NCP_HI_Q24 = 24'd16775538;
    localparam logic [23:0] HALF_Q24 = 24'd8388608;

    // log2(10)/10 in Q24 and 0.001*log2(e) in Q32.
    localparam logic [22:0] DB_TO_LOG2_Q24 = 23'd5573271;
    localparam logic [22:0] LOG2E_MILLI_Q32 = 23'd6196328;

    // Fluctuation thresholds in Q16: 2.0 and 4000.0.
    localparam logic [44:0] FL_LO_Q16 = 45'd131072;
    localparam logic [44:0] FL_HI_Q16 = 45'd262144000;

endpackage

// File: src/ncpq_delay.sv
// Enabled shift line that keeps side data aligned with the arithmetic pipelines.
module ncpq_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_tap
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sr_reg[k] <= d;
                end
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sr_reg[k] <= sr_reg[k-1];
                end
            end
        end
    end

    assign q = sr_reg[N-1];

endmodule

// File: src/ncpq_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ncpq_isqrt #(
    parameter int W = 48
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   x,
    output logic [W/2-1:0] root
);

    localparam int N = W / 2;

    logic [N:0]   rem_reg  [0:N-2];
    logic [W-1:0] x_reg    [0:N-2];
    logic [N-1:0] root_reg [0:N-1];

    logic [N:0]   p_rem   [0:N-1];
    logic [N-1:0] p_root  [0:N-1];
    logic [W-1:0] p_x     [0:N-1];
    logic [N+1:0] remx_w  [0:N-1];
    logic [N+1:0] trial_w [0:N-1];
    logic [N+1:0] diff_w  [0:N-1];
    logic         ge_w    [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == 0) begin : g_src_in
            assign p_rem[k]  = '0;
            assign p_root[k] = '0;
            assign p_x[k]    = x;
        end else begin : g_src_reg
            assign p_rem[k]  = rem_reg[k-1];
            assign p_root[k] = root_reg[k-1];
            assign p_x[k]    = x_reg[k-1];
        end

        // Bring down the next bit pair and try the next root bit.
        assign remx_w[k]  = {p_rem[k][N-1:0], p_x[k][W-1:W-2]};
        assign trial_w[k] = {p_root[k], 2'b01};
        assign diff_w[k]  = remx_w[k] - trial_w[k];
        assign ge_w[k]    = remx_w[k] >= trial_w[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {p_root[k][N-2:0], ge_w[k]};
            end
        end

        if (k < N - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge_w[k] ? diff_w[k][N:0] : remx_w[k][N:0];
                    x_reg[k]   <= {p_x[k][W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

// File: src/ncpq_fdiv.sv
// Pipelined fraction divider: q = floor(a * 2^FRAC / d) for a <= d, one bit per stage.
module ncpq_fdiv #(
    parameter int DW = 32,
    parameter int FRAC = 30
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] a,
    input  logic [DW-1:0] d,
    output logic [FRAC:0] q
);

    logic [DW-1:0] r_reg [0:FRAC-1];
    logic [DW-1:0] d_reg [0:FRAC-1];
    logic [FRAC:0] q_reg [0:FRAC];

    logic          int_bit_w;
    logic [DW:0]   r2_w   [1:FRAC];
    logic [DW:0]   rd_w   [1:FRAC];
    logic          bit_w  [1:FRAC];

    // The integer bit is set when a is at least d, which for a <= d means a equals d.
    assign int_bit_w = a >= d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0] <= int_bit_w ? DW'(a - d) : a;
            d_reg[0] <= d;
            q_reg[0] <= {{FRAC{1'b0}}, int_bit_w};
        end
    end

    for (genvar k = 1; k <= FRAC; k++) begin : g_stage
        assign r2_w[k]  = {r_reg[k-1], 1'b0};
        assign rd_w[k]  = r2_w[k] - {1'b0, d_reg[k-1]};
        assign bit_w[k] = r2_w[k] >= {1'b0, d_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= {q_reg[k-1][FRAC-1:0], bit_w[k]};
            end
        end

        if (k < FRAC) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= bit_w[k] ? rd_w[k][DW-1:0] : r2_w[k][DW-1:0];
                    d_reg[k] <= d_reg[k-1];
                end
            end
        end
    end

    assign q = q_reg[FRAC];

endmodule

// File: src/ncpq_pow2.sv
// Pipelined 2^-e for an unsigned Q16 exponent, result in Q30, one square root per fraction bit.
module ncpq_pow2 #(
    parameter int EW = 23
) (
    input  logic           clk,
    input  logic           en,
    input  logic [EW-1:0]  e,
    output ncpq_pkg::q30_t p
);

    import ncpq_pkg::*;

    localparam int NW = EW - POW2_BITS;

    q30_t            g_w  [0:POW2_BITS];
    q30_t            v_w  [0:POW2_BITS-1];
    logic [SQ_W-1:0] sx_w [0:POW2_BITS-1];
    logic [EW-1:0]   e_w  [0:POW2_BITS];
    logic [NW-1:0]   n_w;
    q30_t            p_reg;

    assign g_w[0] = ONE_Q30;
    assign e_w[0] = e;

    // Fraction bits are applied from the least significant one up: each stage
    // halves the running value when its bit is set and takes the square root.
    for (genvar j = 0; j < POW2_BITS; j++) begin : g_bit
        assign v_w[j]  = e_w[j][j] ? (g_w[j] >> 1) : g_w[j];
        assign sx_w[j] = {1'b0, v_w[j], {Q30_FRAC{1'b0}}};

        ncpq_isqrt #(
            .W (SQ_W)
        ) u_sqrt (
            .clk  (clk),
            .en   (en),
            .x    (sx_w[j]),
            .root (g_w[j+1])
        );

        ncpq_delay #(
            .W (EW),
            .N (SQ_STEPS)
        ) u_exp_dly (
            .clk (clk),
            .en  (en),
            .d   (e_w[j]),
            .q   (e_w[j+1])
        );
    end

    assign n_w = e_w[POW2_BITS][EW-1:POW2_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (32'(n_w) >= 32'(Q30_W))
            begin
                p_reg <= '0;
            end
            else
            begin
                p_reg <= g_w[POW2_BITS] >> n_w;
            end
        end
    end

    assign p = p_reg;

endmodule

// File: src/ncp_quality_estimator_core.sv
// Top level of the NCP quality estimator: input stage, branch alignment and output stage.
//
// Computes one normalized coherent power quality word per range gate. A gate word
// is taken on every clock while the output side keeps up, and its result passes
// through 532 register stages on its way to the output; that depth is set by the
// SNR branch, a chain of sixteen bit-per-stage square-root pipelines (31 stages
// each) followed by a 31-stage divider. A stall on the output holds the whole
// pipeline in place, so the input stall follows it in the same cycle.
// The min_gate register is written through cfg_wr_en and cfg_wr_data and should only
// change while no gate is in flight.
module ncp_quality_estimator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [9:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] sum_real,
    input  logic signed [23:0] sum_imag,
    input  logic [47:0]        power_denominator,
    input  logic [9:0]         pixel_count,
    input  logic signed [15:0] strength_db,
    input  logic signed [15:0] fluct_snr,
    input  logic [9:0]         gate_index,
    input  logic [16:0]        prior_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        ncp_value,
    output logic               was_updated
);

    import ncpq_pkg::*;

    // Stage numbers, counted in register stages after the input edge.
    localparam int T_IN    = 1;
    localparam int T_NUM   = T_IN + 2;
    localparam int T_FLQ   = T_NUM + 1;
    localparam int T_ESNR  = T_IN + 1;
    localparam int T_S     = T_IN + (CNT_FRAC + 1) + CNT_FRAC / 2;
    localparam int T_RATIO = T_NUM + Q24_FRAC + 1;
    localparam int T_VQ    = T_S + Q24_FRAC + 1;
    localparam int T_V     = T_VQ + 1;
    localparam int T_T     = T_ESNR + POW2_LAT;
    localparam int T_FAC   = T_T + Q30_FRAC + 1;
    localparam int T_P     = T_FLQ + POW2_LAT;
    localparam int T_C     = T_P + 1;
    localparam int T_M1    = T_FAC + 1;
    localparam int T_OUT   = T_M1 + 1;

    function automatic logic [23:0] mag24(input logic [23:0] x);
        return x[23] ? (~x + 24'd1) : x;
    endfunction

    function automatic logic [15:0] mag16(input logic [15:0] x);
        return x[15] ? (~x + 16'd1) : x;
    endfunction

    logic             en;
    logic [T_OUT-1:0] vld_reg;
    logic [9:0]       min_gate_reg;

    // Input stage.
    logic        skip_w;
    logic [9:0]  cnt_sat_w;
    logic [23:0] mr1_reg;
    logic [23:0] mi1_reg;
    logic [47:0] den1_reg;
    logic [9:0]  cnt1_reg;
    logic        isone1_reg;
    logic [15:0] smag1_reg;
    logic        spos1_reg;
    logic [15:0] fm1_reg;
    logic [17:0] keep1_reg;

    // Squares and exponent products.
    logic [47:0] mr_sq_reg;
    logic [47:0] mi_sq_reg;
    logic [47:0] den2_reg;
    logic [38:0] esnr_reg;
    logic [31:0] fm_sq_reg;
    logic [47:0] num3_reg;
    logic [47:0] den3_reg;
    logic [63:0] fm4_w;
    logic [44:0] fq3_reg;
    logic [27:0] fdiff_w;
    logic [50:0] flp_w;
    logic [50:0] flp_reg;
    logic [1:0]  flflag_reg;

    // Ratio, bias and clamp.
    logic [47:0] ratio_a_w;
    logic [24:0] ratio_w;
    logic [24:0] ratio_d;
    logic [48:0] cq_w;
    logic [23:0] s_w;
    logic        low_w;
    logic [24:0] va_w;
    logic [24:0] vd_w;
    logic [24:0] vq_w;
    logic        low_d;
    logic        isone_d;
    logic [23:0] v_next;
    logic [23:0] v_reg;
    logic [23:0] v_d;

    // SNR factor.
    q30_t        t_w;
    logic        spos_d;
    logic [31:0] fa_w;
    logic [31:0] fd_w;
    q30_t        fac_w;

    // Fluctuation correction.
    q30_t        p_w;
    logic [1:0]  flflag_d;
    q30_t        corr_next;
    q30_t        corr_reg;
    q30_t        corr_d;

    // Output products.
    logic [54:0] m1p_w;
    logic [23:0] m1_reg;
    logic [54:0] m2p_w;
    logic [17:0] keep_d;
    logic [16:0] ncp_reg;
    logic        upd_reg;

    // The whole pipeline advances unless a finished word is held at the output.
    assign en       = !vld_reg[T_OUT-1] || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[T_OUT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gate_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            min_gate_reg <= cfg_wr_data;
        end
    end

    assign skip_w = (power_denominator == '0) || (pixel_count == '0) ||
                    ((sum_real == '0) && (sum_imag == '0)) ||
                    (gate_index < min_gate_reg) || (32'(gate_index) >= MAX_GATES);

    assign cnt_sat_w = (32'(pixel_count) > MAX_COUNT) ? 10'(MAX_COUNT) : pixel_count;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr1_reg    <= mag24(sum_real);
            mi1_reg    <= mag24(sum_imag);
            den1_reg   <= power_denominator;
            cnt1_reg   <= cnt_sat_w;
            isone1_reg <= cnt_sat_w == 10'd1;
            smag1_reg  <= mag16(strength_db);
            spos1_reg  <= !strength_db[15] && (strength_db != '0);
            fm1_reg    <= mag16(fluct_snr);
            keep1_reg  <= {skip_w, prior_value};
        end
    end

    assign fm4_w   = fm_sq_reg * fm_sq_reg;
    assign fdiff_w = 28'(fq3_reg - FL_LO_Q16);
    assign flp_w   = fdiff_w * LOG2E_MILLI_Q32;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr_sq_reg  <= mr1_reg * mr1_reg;
            mi_sq_reg  <= mi1_reg * mi1_reg;
            den2_reg   <= den1_reg;
            esnr_reg   <= smag1_reg * DB_TO_LOG2_Q24;
            fm_sq_reg  <= fm1_reg * fm1_reg;
            num3_reg   <= mr_sq_reg + mi_sq_reg;
            den3_reg   <= den2_reg;
            fq3_reg    <= fm4_w[60:16];
            flp_reg    <= flp_w;
            flflag_reg <= {fq3_reg <= FL_LO_Q16, fq3_reg >= FL_HI_Q16};
        end
    end

    // A ratio of one or more is divided as den / den, which gives exactly 1.0.
    assign ratio_a_w = (num3_reg >= den3_reg) ? den3_reg : num3_reg;

    ncpq_fdiv #(
        .DW   (48),
        .FRAC (Q24_FRAC)
    ) u_ratio_div (
        .clk (clk),
        .en  (en),
        .a   (ratio_a_w),
        .d   (den3_reg),
        .q   (ratio_w)
    );

    ncpq_delay #(
        .W (25),
        .N (T_S - T_RATIO)
    ) u_ratio_dly (
        .clk (clk),
        .en  (en),
        .d   (ratio_w),
        .q   (ratio_d)
    );

    // Bias term 1/sqrt(count) as isqrt(2^48 / count).
    ncpq_fdiv #(
        .DW   (10),
        .FRAC (CNT_FRAC)
    ) u_cnt_div (
        .clk (clk),
        .en  (en),
        .a   (10'd1),
        .d   (cnt1_reg),
        .q   (cq_w)
    );

    ncpq_isqrt #(
        .W (CNT_FRAC)
    ) u_bias_sqrt (
        .clk  (clk),
        .en   (en),
        .x    (cq_w[CNT_FRAC-1:0]),
        .root (s_w)
    );

    assign low_w = ratio_d <= {1'b0, s_w};
    assign va_w  = low_w ? '0 : (ratio_d - {1'b0, s_w});
    assign vd_w  = 25'h100_0000 - {1'b0, s_w};

    ncpq_fdiv #(
        .DW   (25),
        .FRAC (Q24_FRAC)
    ) u_bias_div (
        .clk (clk),
        .en  (en),
        .a   (va_w),
        .d   (vd_w),
        .q   (vq_w)
    );

    ncpq_delay #(
        .W (1),
        .N (T_VQ - T_S)
    ) u_low_dly (
        .clk (clk),
        .en  (en),
        .d   (low_w),
        .q   (low_d)
    );

    ncpq_delay #(
        .W (1),
        .N (T_VQ - T_IN)
    ) u_isone_dly (
        .clk (clk),
        .en  (en),
        .d   (isone1_reg),
        .q   (isone_d)
    );

    always_comb
    begin
        if (isone_d)
        begin
            v_next = HALF_Q24;
        end
        else if (low_d || (vq_w < {1'b0, NCP_LO_Q24}))
        begin
            v_next = NCP_LO_Q24;
        end
        else if (vq_w > {1'b0, NCP_HI_Q24})
        begin
            v_next = NCP_HI_Q24;
        end
        else
        begin
            v_next = vq_w[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
        end
    end

    ncpq_delay #(
        .W (24),
        .N (T_FAC - T_V)
    ) u_v_dly (
        .clk (clk),
        .en  (en),
        .d   (v_reg),
        .q   (v_d)
    );

    ncpq_pow2 #(
        .EW (23)
    ) u_snr_pow2 (
        .clk (clk),
        .en  (en),
        .e   (esnr_reg[38:16]),
        .p   (t_w)
    );

    ncpq_delay #(
        .W (1),
        .N (T_T - T_IN)
    ) u_spos_dly (
        .clk (clk),
        .en  (en),
        .d   (spos1_reg),
        .q   (spos_d)
    );

    // Positive strength gives 1/(1+t), otherwise t/(1+t).
    assign fa_w = spos_d ? {1'b0, ONE_Q30} : {1'b0, t_w};
    assign fd_w = {1'b0, ONE_Q30} + {1'b0, t_w};

    ncpq_fdiv #(
        .DW   (32),
        .FRAC (Q30_FRAC)
    ) u_snr_div (
        .clk (clk),
        .en  (en),
        .a   (fa_w),
        .d   (fd_w),
        .q   (fac_w)
    );

    ncpq_pow2 #(
        .EW (19)
    ) u_fl_pow2 (
        .clk (clk),
        .en  (en),
        .e   (flp_reg[50:32]),
        .p   (p_w)
    );

    ncpq_delay #(
        .W (2),
        .N (T_P - T_FLQ)
    ) u_flflag_dly (
        .clk (clk),
        .en  (en),
        .d   (flflag_reg),
        .q   (flflag_d)
    );

    always_comb
    begin
        if (flflag_d[1])
        begin
            corr_next = ONE_Q30;
        end
        else if (flflag_d[0] || (p_w < TENTH_Q30))
        begin
            corr_next = TENTH_Q30;
        end
        else
        begin
            corr_next = p_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            corr_reg <= corr_next;
        end
    end

    ncpq_delay #(
        .W (Q30_W),
        .N (T_M1 - T_C)
    ) u_corr_dly (
        .clk (clk),
        .en  (en),
        .d   (corr_reg),
        .q   (corr_d)
    );

    ncpq_delay #(
        .W (18),
        .N (T_M1 - T_IN)
    ) u_keep_dly (
        .clk (clk),
        .en  (en),
        .d   (keep1_reg),
        .q   (keep_d)
    );

    assign m1p_w = v_d * fac_w;
    assign m2p_w = m1_reg * corr_d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= m1p_w[53:30];
            ncp_reg <= keep_d[17] ? keep_d[16:0] : {1'b0, m2p_w[53:38]};
            upd_reg <= !keep_d[17];
        end
    end

    assign out_valid   = vld_reg[T_OUT-1];
    assign ncp_value   = ncp_reg;
    assign was_updated = upd_reg;

endmodule
